// File: design/rled_pkg.sv
package rled_pkg;

   // Stream geometry.
   localparam int SymBits    = 6;
   localparam int BufBits    = 14;
   localparam int MaxResults = 4;

   typedef enum logic [2:0] {
      HDR_WIDTH_LO,
      HDR_WIDTH_HI,
      HDR_HEIGHT_LO,
      HDR_HEIGHT_HI,
      HDR_ROWS,
      HDR_DONE
   } hdr_phase_type;

   typedef enum logic [1:0] {
      SYM_RUN_COUNT,
      SYM_LIT_COUNT,
      SYM_LITERAL
   } sym_phase_type;

   typedef enum logic [1:0] {
      KIND_LITERAL,
      KIND_ZERO_RUN,
      KIND_PAD
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [SymBits-1:0] pixel_value;
      logic [SymBits-1:0] run_count;
      logic              row_end;
      logic              image_end;
      logic              last_of_item;
   } rsp_item_type;

   typedef rsp_item_type [MaxResults-1:0] rsp_bundle_type;

   typedef struct packed {
      logic [BufBits-1:0] bit_buffer;
      logic [3:0]         bits_held;
      hdr_phase_type      header_phase;
      logic [15:0]        image_width;
      logic [15:0]        rows_left;
      logic [16:0]        column_count;
      sym_phase_type      symbol_phase;
      logic [SymBits-1:0] literals_left;
   } dec_state_type;

   typedef struct packed {
      dec_state_type          st;
      rsp_item_type [1:0]     res;
      logic [1:0]             n;
   } sym_result_type;

   function automatic rsp_item_type make_item(kind_type kind, logic [SymBits-1:0] pix,
                                              logic [SymBits-1:0] cnt, logic rend,
                                              logic iend);
      rsp_item_type it;
      it.kind         = kind;
      it.pixel_value  = pix;
      it.run_count    = cnt;
      it.row_end      = rend;
      it.image_end    = iend;
      it.last_of_item = 1'b0;
      return it;
   endfunction

   // One 6-bit symbol through the group parser; at most two results
   // (a run or literal, then the padding that closes a row).
   function automatic sym_result_type take_symbol(dec_state_type st_in,
                                                  logic [SymBits-1:0] s);
      sym_result_type r;
      logic           group_done;
      logic [15:0]    rows;
      logic [1:0]     pad;
      r          = '0;
      r.st       = st_in;
      group_done = 1'b0;
      rows       = '0;
      pad        = '0;
      case (st_in.symbol_phase)
         SYM_RUN_COUNT: begin
            if (s != '0) begin
               r.res[0] = make_item(KIND_ZERO_RUN, '0, s, 1'b0, 1'b0);
               r.n      = 2'd1;
            end
            r.st.column_count = st_in.column_count + 17'(s);
            r.st.symbol_phase = SYM_LIT_COUNT;
         end
         SYM_LIT_COUNT: begin
            r.st.literals_left = s;
            r.st.column_count  = st_in.column_count + 17'(s);
            if (s == '0) begin
               group_done = 1'b1;
            end else begin
               r.st.symbol_phase = SYM_LITERAL;
            end
         end
         default: begin
            r.res[0]           = make_item(KIND_LITERAL, s, 6'd1, 1'b0, 1'b0);
            r.n                = 2'd1;
            r.st.literals_left = st_in.literals_left - 6'd1;
            if (r.st.literals_left == '0) begin
               group_done = 1'b1;
            end
         end
      endcase
      if (group_done) begin
         r.st.symbol_phase = SYM_RUN_COUNT;
         if (r.st.column_count >= {1'b0, r.st.image_width}) begin
            // Row complete: pad the column count up to a multiple of four.
            pad                = 2'd0 - r.st.column_count[1:0];
            rows               = r.st.rows_left - 16'd1;
            r.res[r.n[0]]      = make_item(KIND_PAD, '0, {4'd0, pad}, 1'b1, rows == '0);
            r.n                = r.n + 2'd1;
            r.st.rows_left     = rows;
            r.st.column_count  = '0;
            r.st.literals_left = '0;
            if (rows == '0) begin
               r.st.header_phase = HDR_DONE;
            end
         end
      end
      return r;
   endfunction

endpackage

// File: design/six_bit_rle_image_decoder.sv
// Path: an accepted byte is held in the input register and decoded from there; its
// results are written into the result queue, from which they are offered.
// Throughput: one byte per cycle while each byte yields at most one result and the
// result port is not held off; a byte yields up to three results, and the result port
// moves one result per cycle, so such a byte occupies the output until all are taken.
// Reset: synchronous, active high; the parser waits for header byte zero.
module six_bit_rle_image_decoder (
   input  logic        clock,
   input  logic        reset,
   // Compressed stream in, one byte per item.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] image_start
   // Decoded results out.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] pixel_value, [11:6] run_count, [15:12] zero
   output logic [3:0]  rsp_tuser,   // [1:0] kind, [2] row_end, [3] image_end
   output logic        rsp_tlast    // last_of_item: final result caused by one byte
);
   import rled_pkg::*;

   // The decode stage holds one input byte in a register and, in a single pass of
   // combinational logic, runs the header parser or appends the byte to the bit
   // buffer and parses the one or two 6-bit symbols it completes. All results of
   // that byte are written together as one bundle into a two-entry result queue.
   // The queue's free flag is registered, so the input ready never depends on the
   // output ready in the same cycle.
   logic           space;
   logic           wr_en;
   rsp_bundle_type wr_bundle;
   rsp_item_type   out_item;

   rled_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_start  (req_tuser),
      .space     (space),
      .wr_en     (wr_en),
      .wr_bundle (wr_bundle)
   );

   // The result queue hands out the results of a bundle one at a time and frees
   // the bundle when its last result is taken.
   rled_resq u_resq (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_bundle (wr_bundle),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {4'd0, out_item.run_count, out_item.pixel_value};
   assign rsp_tuser = {out_item.image_end, out_item.row_end, out_item.kind};
   assign rsp_tlast = out_item.last_of_item;

endmodule

// File: design/rled_decode.sv
module rled_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_start,
   input  logic                   space,
   output logic                   wr_en,
   output rled_pkg::rsp_bundle_type wr_bundle
);
   import rled_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_start_ff;
   dec_state_type state_ff, state_in;
   logic          consume;

   dec_state_type  st;
   sym_result_type r1, r2;
   logic [21:0]    wide;
   logic [3:0]     held;
   rsp_bundle_type items;
   logic [1:0]     n1;
   logic [2:0]     n_total;
   logic [2:0]     last_idx;
   logic [1:0]     pos;

   assign consume  = in_valid_ff && space;
   assign in_ready = !in_valid_ff || space;

   always_comb begin
      st       = in_start_ff ? dec_state_type'('0) : state_ff;
      r1       = '0;
      r2       = '0;
      wide     = '0;
      held     = '0;
      items    = '0;
      n1       = '0;
      n_total  = '0;
      last_idx = '0;
      pos      = '0;
      case (st.header_phase)
         HDR_WIDTH_LO: begin
            st.image_width  = {8'd0, in_byte_ff};
            st.header_phase = HDR_WIDTH_HI;
         end
         HDR_WIDTH_HI: begin
            st.image_width[15:8] = in_byte_ff;
            st.header_phase      = HDR_HEIGHT_LO;
         end
         HDR_HEIGHT_LO: begin
            st.rows_left    = {8'd0, in_byte_ff};
            st.header_phase = HDR_HEIGHT_HI;
         end
         HDR_HEIGHT_HI: begin
            st.rows_left[15:8] = in_byte_ff;
            st.bit_buffer      = '0;
            st.bits_held       = '0;
            st.column_count    = '0;
            st.symbol_phase    = SYM_RUN_COUNT;
            st.literals_left   = '0;
            st.header_phase    = HDR_ROWS;
            if (st.rows_left == '0) begin
               items[0]        = make_item(KIND_PAD, '0, '0, 1'b0, 1'b1);
               n_total         = 3'd1;
               st.header_phase = HDR_DONE;
            end else if (st.image_width == '0) begin
               items[0]        = make_item(KIND_PAD, '0, '0, 1'b1, 1'b1);
               n_total         = 3'd1;
               st.rows_left    = '0;
               st.header_phase = HDR_DONE;
            end
         end
         HDR_ROWS: begin
            wide = {8'd0, st.bit_buffer} | ({14'd0, in_byte_ff} << st.bits_held);
            held = st.bits_held + 4'd8;
            // First symbol: always present, since at least eight bits are held.
            st.bit_buffer = wide[BufBits-1:0] >> SymBits;
            st.bits_held  = held - 4'(SymBits);
            r1 = take_symbol(st, wide[SymBits-1:0]);
            st = r1.st;
            n1 = r1.n;
            items[0] = r1.res[0];
            items[1] = r1.res[1];
            n_total  = {1'b0, n1};
            // Second symbol when enough bits remain and the image is not over.
            if (st.bits_held >= 4'(SymBits) && st.header_phase == HDR_ROWS) begin
               st.bit_buffer = r1.st.bit_buffer >> SymBits;
               st.bits_held  = r1.st.bits_held - 4'(SymBits);
               r2 = take_symbol(st, r1.st.bit_buffer[SymBits-1:0]);
               st = r2.st;
               for (int j = 0; j < 2; j++) begin
                  pos = n1 + 2'(j);
                  if (2'(j) < r2.n) begin
                     items[pos] = r2.res[j];
                  end
               end
               n_total = {1'b0, n1} + {1'b0, r2.n};
            end
         end
         default: begin
         end
      endcase
      if (n_total != '0) begin
         last_idx = n_total - 3'd1;
         items[last_idx[1:0]].last_of_item = 1'b1;
      end
   end

   assign wr_en     = consume && (n_total != '0);
   assign wr_bundle = items;

   assign in_valid_in = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
   assign state_in    = consume ? st : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff  <= in_byte;
         in_start_ff <= in_start;
      end
   end

endmodule

// File: design/rled_resq.sv
module rled_resq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  rled_pkg::rsp_bundle_type wr_bundle,
   output logic                     space,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rled_pkg::rsp_item_type   out_item
);
   import rled_pkg::*;

   rsp_bundle_type bundle_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     used_ff, used_in;
   logic [1:0]     idx_ff, idx_in;
   logic           take, pop;

   assign space     = (used_ff != 2'd2);
   assign out_valid = (used_ff != 2'd0);
   assign out_item  = bundle_ff[rd_ptr_ff][idx_ff];
   assign take      = out_valid && out_ready;
   assign pop       = take && out_item.last_of_item;

   assign wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign idx_in    = pop ? 2'd0 : (take ? idx_ff + 2'd1 : idx_ff);
   assign used_in   = used_ff + {1'b0, wr_en} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bundle_ff[wr_ptr_ff] <= wr_bundle;
      end
   end

endmodule
